// ----- hw/rtl/hsf_pkg.sv -----
// Shared constants and register codes for the 2D spring force pipeline.
// No dependencies; imported by hsf_axis_tail and hooke_spring_force_2d.
package hsf_pkg;

  localparam int unsigned WORD_BITS_DEF = 32;
  localparam int unsigned FRAC_BITS_DEF = 16;
  // Fraction bits of the unit direction vector.
  localparam int unsigned NORM_BITS     = 30;
  // Width of the configuration registers.
  localparam int unsigned CFG_W         = 31;

  typedef enum logic {
    REG_STIFFNESS = 1'b0,
    REG_REST      = 1'b1
  } hsf_reg_e;

endpackage

// ----- hw/rtl/hsf_sqrt_cell.sv -----
// One step of the restoring square root chain: retires one root bit.
// No package dependencies.
module hsf_sqrt_cell #(
  parameter int unsigned STEPS  = 34,
  parameter int unsigned SIDE_W = 68
) (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  logic [STEPS+1:0]      rem_i,
  input  logic [STEPS-1:0]      root_i,
  input  logic [2*STEPS-1:0]    rad_i,
  input  logic [SIDE_W-1:0]     side_i,
  output logic [STEPS+1:0]      rem_o,
  output logic [STEPS-1:0]      root_o,
  output logic [2*STEPS-1:0]    rad_o,
  output logic [SIDE_W-1:0]     side_o
);

  logic [STEPS+1:0]   rem_sh;
  logic [STEPS+1:0]   trial;
  logic               ge;
  logic [STEPS+1:0]   rem_d;
  logic [STEPS-1:0]   root_d;
  logic [2*STEPS-1:0] rad_d;
  logic [STEPS+1:0]   rem_q;
  logic [STEPS-1:0]   root_q;
  logic [2*STEPS-1:0] rad_q;
  logic [SIDE_W-1:0]  side_q;

  always_comb begin
    // bring in the next two radicand bits
    rem_sh = {rem_i[STEPS-1:0], rad_i[2*STEPS-1 -: 2]};
    trial  = {root_i, 2'b01};
    ge     = (rem_sh >= trial);
    rem_d  = ge ? (rem_sh - trial) : rem_sh;
    root_d = {root_i[STEPS-2:0], ge};
    rad_d  = {rad_i[2*STEPS-3:0], 2'b00};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= rem_d;
      root_q <= root_d;
      rad_q  <= rad_d;
      side_q <= side_i;
    end
  end

  assign rem_o  = rem_q;
  assign root_o = root_q;
  assign rad_o  = rad_q;
  assign side_o = side_q;

endmodule

// ----- hw/rtl/hsf_div_cell.sv -----
// One step of the restoring divider chain, x and y lanes sharing one divisor.
// No package dependencies.
module hsf_div_cell #(
  parameter int unsigned LEN_W  = 34,
  parameter int unsigned Q_W    = 31,
  parameter int unsigned SIDE_W = 37
) (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [LEN_W:0]    rem_x_i,
  input  logic [LEN_W:0]    rem_y_i,
  input  logic [LEN_W-1:0]  len_i,
  input  logic [Q_W-1:0]    q_x_i,
  input  logic [Q_W-1:0]    q_y_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic [LEN_W:0]    rem_x_o,
  output logic [LEN_W:0]    rem_y_o,
  output logic [LEN_W-1:0]  len_o,
  output logic [Q_W-1:0]    q_x_o,
  output logic [Q_W-1:0]    q_y_o,
  output logic [SIDE_W-1:0] side_o
);

  logic [LEN_W:0]    dvs;
  logic              ge_x, ge_y;
  logic [LEN_W:0]    r_x, r_y;
  logic [LEN_W:0]    rem_x_q, rem_y_q;
  logic [LEN_W-1:0]  len_q;
  logic [Q_W-1:0]    q_x_q, q_y_q;
  logic [SIDE_W-1:0] side_q;

  always_comb begin
    dvs  = {1'b0, len_i};
    ge_x = (rem_x_i >= dvs);
    ge_y = (rem_y_i >= dvs);
    r_x  = ge_x ? (rem_x_i - dvs) : rem_x_i;
    r_y  = ge_y ? (rem_y_i - dvs) : rem_y_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_x_q <= {r_x[LEN_W-1:0], 1'b0};
      rem_y_q <= {r_y[LEN_W-1:0], 1'b0};
      q_x_q   <= {q_x_i[Q_W-2:0], ge_x};
      q_y_q   <= {q_y_i[Q_W-2:0], ge_y};
      len_q   <= len_i;
      side_q  <= side_i;
    end
  end

  assign rem_x_o = rem_x_q;
  assign rem_y_o = rem_y_q;
  assign len_o   = len_q;
  assign q_x_o   = q_x_q;
  assign q_y_o   = q_y_q;
  assign side_o  = side_q;

endmodule

// ----- hw/rtl/hsf_axis_tail.sv -----
// Force magnitude for one axis: k * n * |ext| in split partial products,
// then scale, clamp and sign. Depends on hsf_pkg.
module hsf_axis_tail #(
  parameter int unsigned WORD_BITS = hsf_pkg::WORD_BITS_DEF,
  parameter int unsigned FRAC_BITS = hsf_pkg::FRAC_BITS_DEF,
  parameter int unsigned E_W       = 34
) (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [hsf_pkg::CFG_W-1:0]   k_i,
  input  logic [hsf_pkg::NORM_BITS:0] nx_i,
  input  logic [E_W-1:0]              mag_e_i,
  input  logic                        neg_i,
  input  logic                        zero_i,
  output logic [WORD_BITS-1:0]        force_o,
  output logic                        sat_o
);
  import hsf_pkg::*;

  localparam int unsigned Q_W  = NORM_BITS + 1;
  localparam int unsigned KN_W = CFG_W + Q_W;
  localparam int unsigned H    = KN_W / 2;
  localparam int unsigned P_W  = KN_W + E_W;
  localparam int unsigned SHR  = FRAC_BITS + NORM_BITS;
  localparam int unsigned SH_W = P_W - SHR;

  logic [KN_W-1:0]      kn_q;
  logic [E_W-1:0]       e1_q;
  logic                 n1_q, z1_q, n2_q, z2_q, n3_q, z3_q;
  logic [H+E_W-1:0]     lo_q;
  logic [KN_W-H+E_W-1:0] hi_q;
  logic [P_W-1:0]       p_q;
  logic [SH_W-1:0]      shifted;
  logic [WORD_BITS-1:0] lim;
  logic                 over;
  logic [WORD_BITS-1:0] mag;
  logic [WORD_BITS-1:0] force_d, force_q;
  logic                 sat_d, sat_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      kn_q    <= KN_W'(k_i) * KN_W'(nx_i);
      e1_q    <= mag_e_i;
      n1_q    <= neg_i;
      z1_q    <= zero_i;
      lo_q    <= (H+E_W)'(kn_q[H-1:0]) * (H+E_W)'(e1_q);
      hi_q    <= (KN_W-H+E_W)'(kn_q[KN_W-1:H]) * (KN_W-H+E_W)'(e1_q);
      n2_q    <= n1_q;
      z2_q    <= z1_q;
      p_q     <= (P_W'(hi_q) << H) + P_W'(lo_q);
      n3_q    <= n2_q;
      z3_q    <= z2_q;
      force_q <= force_d;
      sat_q   <= sat_d;
    end
  end

  always_comb begin
    shifted = SH_W'(p_q >> SHR);
    // negative side may reach one step further
    lim     = {1'b0, {(WORD_BITS-1){1'b1}}} + WORD_BITS'(n3_q);
    over    = (shifted > SH_W'(lim));
    mag     = over ? lim : shifted[WORD_BITS-1:0];
    if (z3_q) begin
      force_d = '0;
      sat_d   = 1'b0;
    end else begin
      force_d = n3_q ? (~mag + WORD_BITS'(1)) : mag;
      sat_d   = over;
    end
  end

  assign force_o = force_q;
  assign sat_o   = sat_q;

endmodule

// ----- hw/rtl/hooke_spring_force_2d.sv -----
// Hooke spring force on a particle from its and its partner's 2D position.
// Stages: difference, square, sum, one root bit per square-root cell, one
// quotient bit per divider cell, four multiply/clamp stages. Throughput: one
// pair per cycle; the whole chain holds while a result waits. Reset clears
// valid bits and loads both registers to 1.0.
module hooke_spring_force_2d #(
  parameter int unsigned WORD_BITS = hsf_pkg::WORD_BITS_DEF,
  parameter int unsigned FRAC_BITS = hsf_pkg::FRAC_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // request in: self_pos_x, self_pos_y, anchor_pos_x, anchor_pos_y (low bit up)
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [((4*WORD_BITS+7)/8)*8-1:0] s_axis_tdata,
  // result out: force_x, force_y (low bit up)
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [((2*WORD_BITS+7)/8)*8-1:0] m_axis_tdata,
  // result flag: saturated
  output logic [0:0]          m_axis_tuser,
  // register port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import hsf_pkg::*;

  localparam int unsigned W       = WORD_BITS;
  localparam int unsigned OUT_TD  = ((2*W+7)/8)*8;
  localparam int unsigned STEPS   = W + 2;            // root bits, also length width
  localparam int unsigned LEN_W   = STEPS;
  localparam int unsigned Q_W     = NORM_BITS + 1;
  localparam int unsigned EXT_W   = ((LEN_W > CFG_W) ? LEN_W : CFG_W) + 1;
  localparam int unsigned E_W     = EXT_W - 1;
  localparam int unsigned SQ_SIDE = 2*(W+1) + 2;
  localparam int unsigned DV_SIDE = E_W + 3;
  localparam int unsigned DEPTH   = STEPS + Q_W + 7;
  localparam logic [W-1:0] MAX_POS = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] MIN_NEG = {1'b1, {(W-1){1'b0}}};

  // ---------------- configuration registers ----------------
  logic [CFG_W-1:0] k_q, rest_q;
  hsf_reg_e         reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = hsf_reg_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q    <= CFG_W'(1) << FRAC_BITS;
      rest_q <= CFG_W'(1) << FRAC_BITS;
    end else if (psel && penable && pwrite) begin
      unique case (reg_sel)
        REG_STIFFNESS: k_q    <= pwdata[CFG_W-1:0];
        REG_REST:      rest_q <= pwdata[CFG_W-1:0];
        default:       k_q    <= k_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_STIFFNESS: prdata = {1'b0, k_q};
      REG_REST:      prdata = {1'b0, rest_q};
      default:       prdata = '0;
    endcase
  end

  // ---------------- flow control ----------------
  // Advance every stage together; hold all of them while the result waits.
  logic [DEPTH-1:0] vld_q;
  logic             adv;

  assign adv           = !vld_q[DEPTH-1] || m_axis_tready;
  assign s_axis_tready = adv;
  assign m_axis_tvalid = vld_q[DEPTH-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[DEPTH-2:0], s_axis_tvalid};
    end
  end

  // ---------------- difference and magnitude ----------------
  logic signed [W:0] dx, dy;
  logic [W:0]        ax0_q, ay0_q;
  logic              sx0_q, sy0_q;

  always_comb begin
    dx = {s_axis_tdata[W-1], s_axis_tdata[W-1:0]}
       - {s_axis_tdata[3*W-1], s_axis_tdata[3*W-1:2*W]};
    dy = {s_axis_tdata[2*W-1], s_axis_tdata[2*W-1:W]}
       - {s_axis_tdata[4*W-1], s_axis_tdata[4*W-1:3*W]};
  end

  logic [2*W+1:0]     sqx_q, sqy_q;
  logic [SQ_SIDE-1:0] side1_q, side2_q;
  logic [2*W+2:0]     sum_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ax0_q   <= dx[W] ? (W+1)'(-dx) : (W+1)'(dx);
      ay0_q   <= dy[W] ? (W+1)'(-dy) : (W+1)'(dy);
      sx0_q   <= dx[W];
      sy0_q   <= dy[W];
      // squares, then their sum
      sqx_q   <= (2*W+2)'(ax0_q) * (2*W+2)'(ax0_q);
      sqy_q   <= (2*W+2)'(ay0_q) * (2*W+2)'(ay0_q);
      side1_q <= {sx0_q, sy0_q, ay0_q, ax0_q};
      sum_q   <= (2*W+3)'(sqx_q) + (2*W+3)'(sqy_q);
      side2_q <= side1_q;
    end
  end

  // ---------------- square-root chain ----------------
  logic [STEPS+1:0]   sq_rem  [STEPS+1];
  logic [STEPS-1:0]   sq_root [STEPS+1];
  logic [2*STEPS-1:0] sq_rad  [STEPS+1];
  logic [SQ_SIDE-1:0] sq_side [STEPS+1];

  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_rad[0]  = {1'b0, sum_q};
  assign sq_side[0] = side2_q;

  for (genvar i = 0; i < STEPS; i++) begin : g_sqrt
    hsf_sqrt_cell #(
      .STEPS  (STEPS),
      .SIDE_W (SQ_SIDE)
    ) u_cell (
      .clk_i  (clk_i),
      .en_i   (adv),
      .rem_i  (sq_rem[i]),
      .root_i (sq_root[i]),
      .rad_i  (sq_rad[i]),
      .side_i (sq_side[i]),
      .rem_o  (sq_rem[i+1]),
      .root_o (sq_root[i+1]),
      .rad_o  (sq_rad[i+1]),
      .side_o (sq_side[i+1])
    );
  end

  // ---------------- extension and sign decisions ----------------
  logic [LEN_W-1:0]   len;
  logic [W:0]         ax_s, ay_s;
  logic               sx_s, sy_s;
  logic [EXT_W-1:0]   ext;
  logic               se, nze;
  logic [E_W-1:0]     mag_e;
  logic               neg_x, neg_y, zero_len;
  logic [DV_SIDE-1:0] dv_side0;

  always_comb begin
    len      = sq_root[STEPS];
    ax_s     = sq_side[STEPS][W:0];
    ay_s     = sq_side[STEPS][2*W+1:W+1];
    sy_s     = sq_side[STEPS][2*W+2];
    sx_s     = sq_side[STEPS][2*W+3];
    ext      = EXT_W'(len) - EXT_W'(rest_q);
    se       = ext[EXT_W-1];
    nze      = (ext != '0);
    mag_e    = se ? E_W'(-ext) : E_W'(ext);
    // pull toward the anchor when stretched, push away when compressed
    neg_x    = (ax_s != '0) && nze && (sx_s == se);
    neg_y    = (ay_s != '0) && nze && (sy_s == se);
    zero_len = (len == '0);
    dv_side0 = {neg_x, neg_y, zero_len, mag_e};
  end

  // ---------------- direction divider chain ----------------
  logic [LEN_W:0]     dv_rem_x [Q_W+1];
  logic [LEN_W:0]     dv_rem_y [Q_W+1];
  logic [LEN_W-1:0]   dv_len   [Q_W+1];
  logic [Q_W-1:0]     dv_q_x   [Q_W+1];
  logic [Q_W-1:0]     dv_q_y   [Q_W+1];
  logic [DV_SIDE-1:0] dv_side  [Q_W+1];

  assign dv_rem_x[0] = (LEN_W+1)'(ax_s);
  assign dv_rem_y[0] = (LEN_W+1)'(ay_s);
  assign dv_len[0]   = len;
  assign dv_q_x[0]   = '0;
  assign dv_q_y[0]   = '0;
  assign dv_side[0]  = dv_side0;

  for (genvar j = 0; j < Q_W; j++) begin : g_div
    hsf_div_cell #(
      .LEN_W  (LEN_W),
      .Q_W    (Q_W),
      .SIDE_W (DV_SIDE)
    ) u_cell (
      .clk_i   (clk_i),
      .en_i    (adv),
      .rem_x_i (dv_rem_x[j]),
      .rem_y_i (dv_rem_y[j]),
      .len_i   (dv_len[j]),
      .q_x_i   (dv_q_x[j]),
      .q_y_i   (dv_q_y[j]),
      .side_i  (dv_side[j]),
      .rem_x_o (dv_rem_x[j+1]),
      .rem_y_o (dv_rem_y[j+1]),
      .len_o   (dv_len[j+1]),
      .q_x_o   (dv_q_x[j+1]),
      .q_y_o   (dv_q_y[j+1]),
      .side_o  (dv_side[j+1])
    );
  end

  // ---------------- per-axis force ----------------
  logic [DV_SIDE-1:0] tl_side;
  logic [W-1:0]       force_x, force_y;
  logic               sat_x, sat_y;

  assign tl_side = dv_side[Q_W];

  hsf_axis_tail #(
    .WORD_BITS (WORD_BITS),
    .FRAC_BITS (FRAC_BITS),
    .E_W       (E_W)
  ) u_tail_x (
    .clk_i   (clk_i),
    .en_i    (adv),
    .k_i     (k_q),
    .nx_i    (dv_q_x[Q_W]),
    .mag_e_i (tl_side[E_W-1:0]),
    .neg_i   (tl_side[E_W+2]),
    .zero_i  (tl_side[E_W]),
    .force_o (force_x),
    .sat_o   (sat_x)
  );

  hsf_axis_tail #(
    .WORD_BITS (WORD_BITS),
    .FRAC_BITS (FRAC_BITS),
    .E_W       (E_W)
  ) u_tail_y (
    .clk_i   (clk_i),
    .en_i    (adv),
    .k_i     (k_q),
    .nx_i    (dv_q_y[Q_W]),
    .mag_e_i (tl_side[E_W-1:0]),
    .neg_i   (tl_side[E_W+1]),
    .zero_i  (tl_side[E_W]),
    .force_o (force_y),
    .sat_o   (sat_y)
  );

  assign m_axis_tdata    = OUT_TD'({force_y, force_x});
  assign m_axis_tuser[0] = sat_x | sat_y;

  // ---------------- checks ----------------
`ifndef SYNTHESIS
  // a clamped result must sit on one of the range bounds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |->
      (force_x == MAX_POS) || (force_x == MIN_NEG) ||
      (force_y == MAX_POS) || (force_y == MIN_NEG))
    else $error("saturated flag without a clamped component");

  // a zero root only comes from coincident points
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[STEPS+2] && (len == '0) |-> (ax_s == '0) && (ay_s == '0))
    else $error("square root returned zero for a nonzero offset");

  // the output register only fills from the stage before it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && !vld_q[DEPTH-2] |=> !m_axis_tvalid)
    else $error("result appeared without an item behind it");
`endif

endmodule
